### hdl/icdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icdf_pkg
// Shared types and Q48 coefficients for the inverse normal cdf pipeline.
// ----------------------------------------------------------------------------
package icdf_pkg;

   // internal signed Q48 word
   typedef logic signed [63:0] q48_type;

   localparam int Q48Frac = 48;
   localparam q48_type Q48One  = 64'sh0001_0000_0000_0000;
   localparam q48_type Q48Half = 64'sh0000_8000_0000_0000;
   localparam q48_type Q48Two  = 64'sh0002_0000_0000_0000;

   // pipeline geometry
   localparam int QmulLat    = 3;
   localparam int SqIters    = 48;
   localparam int SqrtSteps  = 51;
   localparam int DivSteps   = 33;

   localparam logic [127:0] DecScale = 128'd100000000000;

   // decimal constant with eleven decimals to Q48, rounded half away from zero
   function automatic q48_type coef_q48(input logic [127:0] scaled_mag, input logic is_neg);
      logic [127:0] quo;
      logic [63:0]  m;
      quo = (scaled_mag << (Q48Frac + 1)) / DecScale;
      m   = 64'((quo + 128'd1) >> 1);
      return is_neg ? q48_type'(~m + 64'd1) : q48_type'(m);
   endfunction

   // central region limit and ln 2
   localparam q48_type CentLimit = coef_q48(128'd42000000000, 1'b0);
   localparam q48_type Ln2       = coef_q48(128'd69314718056, 1'b0);

   // central numerator, highest power first
   localparam q48_type CentA4 = coef_q48(128'd2544106049637, 1'b1);
   localparam q48_type CentA3 = coef_q48(128'd4139119773534, 1'b0);
   localparam q48_type CentA2 = coef_q48(128'd1861500062529, 1'b1);
   localparam q48_type CentA1 = coef_q48(128'd250662823884, 1'b0);

   // central denominator
   localparam q48_type CentB4 = coef_q48(128'd313082909833, 1'b0);
   localparam q48_type CentB3 = coef_q48(128'd2106224101826, 1'b1);
   localparam q48_type CentB2 = coef_q48(128'd2308336743743, 1'b0);
   localparam q48_type CentB1 = coef_q48(128'd847351093090, 1'b1);

   // tail numerator
   localparam q48_type TailC3 = coef_q48(128'd232121276858, 1'b0);
   localparam q48_type TailC2 = coef_q48(128'd485014127135, 1'b0);
   localparam q48_type TailC1 = coef_q48(128'd229796479134, 1'b1);
   localparam q48_type TailC0 = coef_q48(128'd278718931138, 1'b1);

   // tail denominator
   localparam q48_type TailD2 = coef_q48(128'd163706781897, 1'b0);
   localparam q48_type TailD1 = coef_q48(128'd354388924762, 1'b0);

endpackage

### hdl/icdf_qmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icdf_qmul
// Pipelined signed Q48 multiply, rounded half away from zero.
// ----------------------------------------------------------------------------
module icdf_qmul (
   input  logic              clock,
   input  logic              en,
   input  icdf_pkg::q48_type a,
   input  icdf_pkg::q48_type b,
   output icdf_pkg::q48_type prod
);
   import icdf_pkg::*;

   logic [63:0]  ua;
   logic [63:0]  ub;
   logic [63:0]  ma_ff;
   logic [63:0]  mb_ff;
   logic         sgn1_ff;
   logic         sgn2_ff;
   logic [63:0]  pp00_ff;
   logic [63:0]  pp01_ff;
   logic [63:0]  pp10_ff;
   logic [63:0]  pp11_ff;
   logic [127:0] sum;
   logic [62:0]  m;
   q48_type      prod_in;
   q48_type      prod_ff;

   assign ua = a;
   assign ub = b;

   // magnitudes and sign
   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff   <= a[63] ? (~ua + 64'd1) : ua;
         mb_ff   <= b[63] ? (~ub + 64'd1) : ub;
         sgn1_ff <= a[63] ^ b[63];
      end
   end

   // partial products
   always_ff @(posedge clock) begin
      if (en) begin
         pp00_ff <= {32'd0, ma_ff[31:0]} * {32'd0, mb_ff[31:0]};
         pp01_ff <= {32'd0, ma_ff[31:0]} * {32'd0, mb_ff[63:32]};
         pp10_ff <= {32'd0, ma_ff[63:32]} * {32'd0, mb_ff[31:0]};
         pp11_ff <= {32'd0, ma_ff[63:32]} * {32'd0, mb_ff[63:32]};
         sgn2_ff <= sgn1_ff;
      end
   end

   // sum, round and apply sign
   always_comb begin
      sum = {64'd0, pp00_ff} + {32'd0, pp01_ff, 32'd0} + {32'd0, pp10_ff, 32'd0}
          + {pp11_ff, 64'd0} + {64'd0, Q48Half};
      m   = sum[110:48];
      prod_in = sgn2_ff ? q48_type'(~{1'b0, m} + 64'd1) : q48_type'({1'b0, m});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

### hdl/icdf_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icdf_delay
// Enabled shift line that keeps side data aligned with the arithmetic stages.
// ----------------------------------------------------------------------------
module icdf_delay #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 3
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);
   logic [WIDTH-1:0] pipe_ff [DEPTH];

   // shift on advance
   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            pipe_ff[i] <= pipe_ff[i-1];
         end
      end
   end

   assign dout = pipe_ff[DEPTH-1];

endmodule

### hdl/inverse_normal_cdf.sv
`timescale 1ns / 1ps
// throughput: one transaction per cycle; the whole pipe advances unless the
//   response register is full and stalled, so req_stall follows rsp_stall
// the tail path sets the latency: 48 squaring multiplies for log2, a 51-stage
//   square root and a 33-stage divider, each stage one register
// reset clears all valid bits; data registers are not reset
// ----------------------------------------------------------------------------
// inverse_normal_cdf
// AS111 inverse standard normal cdf, fully pipelined Q48 fixed point.
// ----------------------------------------------------------------------------
module inverse_normal_cdf #(
   parameter int PROB_FRAC_BITS = 32,
   parameter int OUT_FRAC_BITS  = 27
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [PROB_FRAC_BITS:0]   req_probability,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [31:0]        rsp_deviate,
   output logic                      rsp_fault
);
   import icdf_pkg::*;

   localparam int InShift  = Q48Frac - PROB_FRAC_BITS;
   localparam int TailR    = 3 + (SqIters + 1) * QmulLat + SqrtSteps;
   localparam int TailNd   = TailR + 3 * QmulLat;
   localparam int CentNd   = 5 * QmulLat;
   localparam int NumW     = 64 + OUT_FRAC_BITS + 1;
   localparam int HiW      = NumW - DivSteps;
   localparam int CmpW     = (HiW > 64) ? HiW : 64;

   typedef struct packed {
      logic fault;
      logic tail;
      logic neg;
   } meta_type;

   typedef struct packed {
      logic [5:0]  e;
      logic [47:0] frac;
   } aux_type;

   typedef struct packed {
      logic [63:0] rem;
      logic [32:0] lo;
      logic [32:0] quo;
      logic [63:0] d;
      logic        neg;
      logic        dz;
      logic        fault;
      logic        ovf;
   } div_type;

   logic adv;
   logic rsp_valid_ff;

   // pipe advances unless the output holds an untaken transaction
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // ---------------- input stage ----------------
   logic        s1_vld_ff;
   logic [63:0] s1_p_ff;
   logic        s1_fault_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_p_ff     <= 64'(req_probability) << InShift;
         s1_fault_ff <= (req_probability == '0) || req_probability[PROB_FRAC_BITS];
      end
   end

   // ---------------- region select ----------------
   q48_type     q_in;
   logic [63:0] q_mag;
   logic [63:0] s_in;
   logic        s2_vld_ff;
   q48_type     s2_q_ff;
   logic [47:0] s2_s_ff;
   meta_type    s2_meta_ff;

   always_comb begin
      q_in  = q48_type'(s1_p_ff) - Q48Half;
      q_mag = q_in[63] ? (~q_in + 64'd1) : q_in;
      if (s1_fault_ff) begin
         s_in = Q48Half;
      end else if (!q_in[63] && (q_in != 0)) begin
         s_in = Q48One - s1_p_ff;
      end else begin
         s_in = s1_p_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_q_ff          <= q_in;
         s2_s_ff          <= s_in[47:0];
         s2_meta_ff.fault <= s1_fault_ff;
         s2_meta_ff.tail  <= q_mag > 64'(CentLimit);
         s2_meta_ff.neg   <= q_in[63];
      end
   end

   // ---------------- normalize for log ----------------
   logic [5:0]  msb;
   logic [5:0]  s3_e_ff;
   logic [47:0] s3_s_ff;
   q48_type     s4_m_ff;
   logic [5:0]  s4_e_ff;

   always_comb begin
      msb = '0;
      for (int i = 0; i < 48; i++) begin
         if (s2_s_ff[i]) begin
            msb = 6'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_s_ff <= s2_s_ff;
         s3_e_ff <= 6'd48 - msb;
         s4_m_ff <= q48_type'(64'(s3_s_ff) << s3_e_ff);
         s4_e_ff <= s3_e_ff;
      end
   end

   // ---------------- log2 by repeated squaring ----------------
   q48_type             sq_y    [SqIters];
   q48_type             sq_p    [SqIters];
   aux_type             sq_aux  [SqIters+1];
   aux_type             sq_auxd [SqIters];
   logic [SqIters-1:0]  sq_bit;

   assign sq_y[0]   = s4_m_ff;
   assign sq_aux[0] = '{e: s4_e_ff, frac: 48'd0};

   for (genvar k = 0; k < SqIters; k++) begin : g_sq
      icdf_qmul u_sq (
         .clock (clock),
         .en    (adv),
         .a     (sq_y[k]),
         .b     (sq_y[k]),
         .prod  (sq_p[k])
      );

      icdf_delay #(.WIDTH($bits(aux_type)), .DEPTH(QmulLat)) u_aux (
         .clock (clock),
         .en    (adv),
         .din   (sq_aux[k]),
         .dout  (sq_auxd[k])
      );

      assign sq_bit[k]   = sq_p[k] >= Q48Two;
      assign sq_aux[k+1] = '{e: sq_auxd[k].e, frac: {sq_auxd[k].frac[46:0], sq_bit[k]}};

      if (k < SqIters - 1) begin : g_next
         assign sq_y[k+1] = sq_bit[k] ? q48_type'(sq_p[k] >> 1) : sq_p[k];
      end
   end

   // ---------------- -ln s = (e - log2 m) * ln2 ----------------
   q48_type x_ff;
   q48_type nl;

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff <= q48_type'({10'd0, sq_aux[SqIters].e, 48'd0})
               - q48_type'({16'd0, sq_aux[SqIters].frac});
      end
   end

   icdf_qmul u_ln (
      .clock (clock),
      .en    (adv),
      .a     (x_ff),
      .b     (Ln2),
      .prod  (nl)
   );

   // ---------------- square root, one result bit per stage ----------------
   logic [53:0]  sr_rem_ff [SqrtSteps];
   logic [50:0]  sr_res_ff [SqrtSteps];
   logic [101:0] sr_x_ff   [SqrtSteps];

   for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
      logic [53:0]  rem_prev;
      logic [50:0]  res_prev;
      logic [101:0] x_prev;
      logic [53:0]  rem_s;
      logic [53:0]  trial;
      logic         ge;

      if (j == 0) begin : g_first
         assign rem_prev = '0;
         assign res_prev = '0;
         assign x_prev   = {nl[53:0], 48'd0};
      end else begin : g_rest
         assign rem_prev = sr_rem_ff[j-1];
         assign res_prev = sr_res_ff[j-1];
         assign x_prev   = sr_x_ff[j-1];
      end

      assign rem_s = {rem_prev[51:0], x_prev[101:100]};
      assign trial = {1'b0, res_prev, 2'b01};
      assign ge    = rem_s >= trial;

      always_ff @(posedge clock) begin
         if (adv) begin
            sr_rem_ff[j] <= ge ? (rem_s - trial) : rem_s;
            sr_res_ff[j] <= {res_prev[49:0], ge};
            sr_x_ff[j]   <= {x_prev[99:0], 2'b00};
         end
      end
   end

   // ---------------- tail rational ----------------
   q48_type tr;
   q48_type tr_d1;
   q48_type tr_d2;
   q48_type ta1;
   q48_type ta2;
   q48_type ta3;
   q48_type td1;
   q48_type td2;
   q48_type td2_d;
   q48_type tail_num;
   q48_type tail_den;

   assign tr = q48_type'({13'd0, sr_res_ff[SqrtSteps-1]});

   icdf_delay #(.WIDTH(64), .DEPTH(QmulLat)) u_tr1 (
      .clock (clock), .en (adv), .din (tr), .dout (tr_d1));
   icdf_delay #(.WIDTH(64), .DEPTH(2 * QmulLat)) u_tr2 (
      .clock (clock), .en (adv), .din (tr), .dout (tr_d2));

   icdf_qmul u_ta1 (.clock (clock), .en (adv), .a (TailC3), .b (tr), .prod (ta1));
   icdf_qmul u_ta2 (.clock (clock), .en (adv), .a (ta1 + TailC2), .b (tr_d1), .prod (ta2));
   icdf_qmul u_ta3 (.clock (clock), .en (adv), .a (ta2 + TailC1), .b (tr_d2), .prod (ta3));
   icdf_qmul u_td1 (.clock (clock), .en (adv), .a (TailD2), .b (tr), .prod (td1));
   icdf_qmul u_td2 (.clock (clock), .en (adv), .a (td1 + TailD1), .b (tr_d1), .prod (td2));

   icdf_delay #(.WIDTH(64), .DEPTH(QmulLat)) u_td2d (
      .clock (clock), .en (adv), .din (td2), .dout (td2_d));

   assign tail_num = ta3 + TailC0;
   assign tail_den = td2_d + Q48One;

   // ---------------- central rational ----------------
   q48_type cr;
   q48_type cr_d1;
   q48_type cr_d2;
   q48_type cr_d3;
   q48_type cq_d;
   q48_type cn1;
   q48_type cn2;
   q48_type cn3;
   q48_type cn4;
   q48_type cm1;
   q48_type cm2;
   q48_type cm3;
   q48_type cm4;
   q48_type cent_num;
   q48_type cent_den;

   icdf_qmul u_cr (.clock (clock), .en (adv), .a (s2_q_ff), .b (s2_q_ff), .prod (cr));

   icdf_delay #(.WIDTH(64), .DEPTH(4 * QmulLat)) u_cq (
      .clock (clock), .en (adv), .din (s2_q_ff), .dout (cq_d));
   icdf_delay #(.WIDTH(64), .DEPTH(QmulLat)) u_cr1 (
      .clock (clock), .en (adv), .din (cr), .dout (cr_d1));
   icdf_delay #(.WIDTH(64), .DEPTH(2 * QmulLat)) u_cr2 (
      .clock (clock), .en (adv), .din (cr), .dout (cr_d2));
   icdf_delay #(.WIDTH(64), .DEPTH(3 * QmulLat)) u_cr3 (
      .clock (clock), .en (adv), .din (cr), .dout (cr_d3));

   icdf_qmul u_cn1 (.clock (clock), .en (adv), .a (CentA4), .b (cr), .prod (cn1));
   icdf_qmul u_cn2 (.clock (clock), .en (adv), .a (cn1 + CentA3), .b (cr_d1), .prod (cn2));
   icdf_qmul u_cn3 (.clock (clock), .en (adv), .a (cn2 + CentA2), .b (cr_d2), .prod (cn3));
   icdf_qmul u_cn4 (.clock (clock), .en (adv), .a (cq_d), .b (cn3 + CentA1), .prod (cn4));
   icdf_qmul u_cm1 (.clock (clock), .en (adv), .a (CentB4), .b (cr), .prod (cm1));
   icdf_qmul u_cm2 (.clock (clock), .en (adv), .a (cm1 + CentB3), .b (cr_d1), .prod (cm2));
   icdf_qmul u_cm3 (.clock (clock), .en (adv), .a (cm2 + CentB2), .b (cr_d2), .prod (cm3));
   icdf_qmul u_cm4 (.clock (clock), .en (adv), .a (cm3 + CentB1), .b (cr_d3), .prod (cm4));

   // align central result with the tail path
   icdf_delay #(.WIDTH(128), .DEPTH(TailNd - CentNd)) u_cal (
      .clock (clock),
      .en    (adv),
      .din   ({cn4, cm4 + Q48One}),
      .dout  ({cent_num, cent_den})
   );

   // ---------------- side data and valid alignment ----------------
   meta_type          meta_d;
   logic [TailNd-1:0] vd_ff;

   icdf_delay #(.WIDTH($bits(meta_type)), .DEPTH(TailNd)) u_meta (
      .clock (clock), .en (adv), .din (s2_meta_ff), .dout (meta_d));

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= '0;
      end else if (adv) begin
         vd_ff <= {vd_ff[TailNd-2:0], s2_vld_ff};
      end
   end

   // ---------------- merge ----------------
   logic    f_vld_ff;
   q48_type f_num_ff;
   q48_type f_den_ff;
   logic    f_neg_ff;
   logic    f_fault_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         f_num_ff   <= meta_d.tail ? tail_num : cent_num;
         f_den_ff   <= meta_d.tail ? tail_den : cent_den;
         f_neg_ff   <= meta_d.tail & meta_d.neg;
         f_fault_ff <= meta_d.fault;
      end
   end

   // ---------------- magnitudes and sign ----------------
   logic        g_vld_ff;
   logic [63:0] g_n_ff;
   logic [63:0] g_d_ff;
   logic        g_neg_ff;
   logic        g_dz_ff;
   logic        g_fault_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         g_n_ff     <= f_num_ff[63] ? (~f_num_ff + 64'd1) : f_num_ff;
         g_d_ff     <= f_den_ff[63] ? (~f_den_ff + 64'd1) : f_den_ff;
         g_neg_ff   <= f_neg_ff ^ f_num_ff[63] ^ f_den_ff[63];
         g_dz_ff    <= f_den_ff == 0;
         g_fault_ff <= f_fault_ff;
      end
   end

   // ---------------- divider setup and overflow check ----------------
   logic [NumW-1:0] g_wide;
   logic [HiW-1:0]  g_hi;
   logic            h_vld_ff;
   div_type         h_ff;

   assign g_wide = {g_n_ff, {(OUT_FRAC_BITS + 1){1'b0}}};
   assign g_hi   = g_wide[NumW-1:DivSteps];

   always_ff @(posedge clock) begin
      if (adv) begin
         h_ff.rem   <= 64'(g_hi);
         h_ff.lo    <= g_wide[DivSteps-1:0];
         h_ff.quo   <= '0;
         h_ff.d     <= g_d_ff;
         h_ff.neg   <= g_neg_ff;
         h_ff.dz    <= g_dz_ff;
         h_ff.fault <= g_fault_ff;
         h_ff.ovf   <= CmpW'(g_hi) >= CmpW'(g_d_ff);
      end
   end

   // ---------------- restoring divider, one quotient bit per stage ----------------
   div_type              dv_ff [DivSteps];
   logic [DivSteps-1:0]  dv_vld_ff;

   for (genvar j = 0; j < DivSteps; j++) begin : g_div
      div_type     prev;
      div_type     stage_in;
      logic [64:0] rem_s;
      logic        ge;

      if (j == 0) begin : g_first
         assign prev = h_ff;
      end else begin : g_rest
         assign prev = dv_ff[j-1];
      end

      assign rem_s = {prev.rem, prev.lo[DivSteps-1]};
      assign ge    = rem_s >= {1'b0, prev.d};

      // next stage word: shifted remainder, one more quotient bit
      always_comb begin
         stage_in     = prev;
         stage_in.rem = ge ? 64'(rem_s - {1'b0, prev.d}) : rem_s[63:0];
         stage_in.lo  = {prev.lo[DivSteps-2:0], 1'b0};
         stage_in.quo = {prev.quo[DivSteps-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_ff[j] <= stage_in;
         end
      end
   end

   // ---------------- round, saturate, sign ----------------
   div_type        dl;
   logic [33:0]    qp1;
   logic [31:0]    mag32;
   logic           sat;
   logic [31:0]    dev_in;
   logic [31:0]    rsp_deviate_ff;
   logic           rsp_fault_ff;

   assign dl = dv_ff[DivSteps-1];

   always_comb begin
      qp1 = {1'b0, dl.quo} + 34'd1;
      sat = dl.ovf || (dl.quo >= 33'h0_FFFF_FFFF);
      if (sat) begin
         mag32 = dl.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         mag32 = qp1[32:1];
      end
      if (dl.fault || dl.dz) begin
         dev_in = '0;
      end else if (dl.neg) begin
         dev_in = ~mag32 + 32'd1;
      end else begin
         dev_in = mag32;
      end
   end

   // ---------------- valid chain after the merge ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff     <= 1'b0;
         g_vld_ff     <= 1'b0;
         h_vld_ff     <= 1'b0;
         dv_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         f_vld_ff     <= vd_ff[TailNd-1];
         g_vld_ff     <= f_vld_ff;
         h_vld_ff     <= g_vld_ff;
         dv_vld_ff    <= {dv_vld_ff[DivSteps-2:0], h_vld_ff};
         rsp_valid_ff <= dv_vld_ff[DivSteps-1];
      end
   end

   // output transaction register
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_deviate_ff <= dev_in;
         rsp_fault_ff   <= dl.fault;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_deviate = signed'(rsp_deviate_ff);
   assign rsp_fault   = rsp_fault_ff;

endmodule
